/* src/lbvs_pkg.sv */
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types, constants and fixed-point helpers for the vertex skinner.
// ----------------------------------------------------------------------------
package lbvs_pkg;

    localparam int              BoneCountDef = 64;
    localparam logic [6:0]      FinalSlot    = 7'd64;
    localparam logic [31:0]     OneQ16       = 32'h0001_0000;
    localparam logic            CmdWrite     = 1'b0;
    localparam logic            CmdSkin      = 1'b1;

    localparam logic signed [49:0] MaxQ = 50'sd2147483647;
    localparam logic signed [49:0] MinQ = -MaxQ - 50'sd1;

    // 4x4 matrix of Q16.16 words, column-major, element 0 in the low bits
    typedef logic [15:0][31:0] mat_t;

    // clamp to signed 32 bits; returns {clamped, value}
    function automatic logic [32:0] sat32(input logic signed [49:0] v);
        logic [32:0] res;
        if (v > MaxQ) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < MinQ) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // Q32.32 product to Q16.16: add half an LSB, floor
    function automatic logic signed [49:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return {{2{t[63]}}, t[63:16]};
    endfunction

endpackage

/* src/lbvs_bone_mem.sv */
// ----------------------------------------------------------------------------
// lbvs_bone_mem
// Four replicated bone tables, one full matrix per entry, one read each.
// ----------------------------------------------------------------------------
module lbvs_bone_mem
    import lbvs_pkg::*;
#(
    parameter int BONE_COUNT = BoneCountDef
) (
    input  logic            aclk,
    input  logic            rd_en,
    input  logic            wr_en,
    input  logic [7:0]      wr_addr,
    input  logic [3:0]      wr_elem,
    input  logic [31:0]     wr_data,
    input  logic [3:0][7:0] rd_addr,
    output mat_t [3:0]      rd_data
);
    localparam int Aw = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    for (genvar k = 0; k < 4; k++) begin : g_copy
        mat_t mem [BONE_COUNT];
        mat_t rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr[Aw-1:0]][wr_elem] <= wr_data;
            end
            if (rd_en) begin
                rd_reg <= mem[rd_addr[k][Aw-1:0]];
            end
        end

        assign rd_data[k] = rd_reg;
    end

endmodule

/* src/lbvs_blend.sv */
// ----------------------------------------------------------------------------
// lbvs_blend
// Weighted sum of four bone matrices: multiply stage, then sum/round/clamp.
// ----------------------------------------------------------------------------
module lbvs_blend
    import lbvs_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  mat_t [3:0]  bones,
    input  logic [63:0] weights,
    output mat_t        blend,
    output logic        sat
);
    logic signed [48:0] prod_reg [16][4];
    mat_t               blend_reg;
    logic               sat_reg;
    mat_t               blend_next;
    logic [15:0]        sat_vec;

    always_comb begin
        logic signed [50:0] acc;
        logic signed [50:0] rnd;
        logic [32:0]        s;
        for (int e = 0; e < 16; e++) begin
            acc = 51'(prod_reg[e][0]) + 51'(prod_reg[e][1])
                + 51'(prod_reg[e][2]) + 51'(prod_reg[e][3]) + 51'sd16384;
            rnd = acc >>> 15;
            s   = sat32(rnd[49:0]);
            blend_next[e] = s[31:0];
            sat_vec[e]    = s[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int e = 0; e < 16; e++) begin
                for (int k = 0; k < 4; k++) begin
                    prod_reg[e][k] <= $signed(bones[k][e])
                                    * $signed({1'b0, weights[16*k +: 16]});
                end
            end
            blend_reg <= blend_next;
            sat_reg   <= |sat_vec;
        end
    end

    assign blend = blend_reg;
    assign sat   = sat_reg;

endmodule

/* src/lbvs_combine.sv */
// ----------------------------------------------------------------------------
// lbvs_combine
// Final matrix times blended matrix: product stage, then round/sum/clamp.
// ----------------------------------------------------------------------------
module lbvs_combine
    import lbvs_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  mat_t fin,
    input  mat_t blend,
    input  logic sat_in,
    output mat_t comb,
    output logic sat
);
    logic signed [63:0] prod_reg [16][4];
    logic               sat_d_reg;
    mat_t               comb_reg;
    logic               sat_reg;
    mat_t               comb_next;
    logic [15:0]        sat_vec;

    always_comb begin
        logic signed [49:0] acc;
        logic [32:0]        s;
        for (int e = 0; e < 16; e++) begin
            acc = rnd16(prod_reg[e][0]) + rnd16(prod_reg[e][1])
                + rnd16(prod_reg[e][2]) + rnd16(prod_reg[e][3]);
            s   = sat32(acc);
            comb_next[e] = s[31:0];
            sat_vec[e]   = s[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    for (int k = 0; k < 4; k++) begin
                        prod_reg[c*4+r][k] <= $signed(fin[k*4+r]) * $signed(blend[c*4+k]);
                    end
                end
            end
            sat_d_reg <= sat_in;
            comb_reg  <= comb_next;
            sat_reg   <= sat_d_reg | (|sat_vec);
        end
    end

    assign comb = comb_reg;
    assign sat  = sat_reg;

endmodule

/* src/lbvs_xform.sv */
// ----------------------------------------------------------------------------
// lbvs_xform
// Applies the combined matrix to (x,y,z,1): product stage, then round/sum/clamp.
// ----------------------------------------------------------------------------
module lbvs_xform
    import lbvs_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  mat_t             comb,
    input  logic [2:0][31:0] pos,
    input  logic             sat_in,
    output logic [2:0][31:0] res,
    output logic             sat
);
    logic signed [63:0] prod_reg [3][3];
    logic [2:0][31:0]   trans_reg;
    logic               sat_d_reg;
    logic [2:0][31:0]   res_reg;
    logic               sat_reg;
    logic [2:0][31:0]   res_next;
    logic [2:0]         sat_vec;

    // w = 1.0, so the translation column passes through unrounded
    always_comb begin
        logic signed [49:0] acc;
        logic [32:0]        s;
        for (int r = 0; r < 3; r++) begin
            acc = rnd16(prod_reg[r][0]) + rnd16(prod_reg[r][1]) + rnd16(prod_reg[r][2])
                + 50'($signed(trans_reg[r]));
            s   = sat32(acc);
            res_next[r] = s[31:0];
            sat_vec[r]  = s[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= $signed(comb[c*4+r]) * $signed(pos[c]);
                end
                trans_reg[r] <= comb[12+r];
            end
            sat_d_reg <= sat_in;
            res_reg   <= res_next;
            sat_reg   <= sat_d_reg | (|sat_vec);
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

/* src/linear_blend_vertex_skinning.sv */
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Four-weight linear blend skinning of Q16.16 vertices against a bone table.
// ----------------------------------------------------------------------------
// Channel | Dir | Carries
// s_*     | in  | write-element or skin-vertex transaction (tuser = command)
// m_*     | out | skinned x,y,z; tuser = {bad_index, saturated}
//
// One transaction per cycle sustained while m_tready is high; skin results pass
// through the table read, blend, matrix product and vertex transform stages.
// Write transactions produce no result and land in the table at acceptance,
// so a skin right behind a write already sees the new value.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
// Reset loads the identity into the final matrix and empties the pipeline;
// the bone table is not cleared.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning
    import lbvs_pkg::*;
#(
    parameter int BONE_COUNT = BoneCountDef
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // matrix_slot, element_index, element_value, bone_indices, weights,
    // pos_x, pos_y, pos_z (5 zero pad bits on top)
    input  logic [239:0] s_tdata,
    input  logic         s_tuser,     // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,     // out_x, out_y, out_z
    output logic [1:0]   m_tuser      // saturated, bad_index
);
    localparam int         Depth   = 7;
    localparam logic [8:0] BoneLim = 9'(BONE_COUNT);

    // input field unpack
    logic [6:0]       matrix_slot;
    logic [3:0]       element_index;
    logic [31:0]      element_value;
    logic [31:0]      bone_indices;
    logic [63:0]      weights;
    logic [2:0][31:0] pos;

    assign matrix_slot   = s_tdata[6:0];
    assign element_index = s_tdata[10:7];
    assign element_value = s_tdata[42:11];
    assign bone_indices  = s_tdata[74:43];
    assign weights       = s_tdata[138:75];
    assign pos           = s_tdata[234:139];

    // one global advance: the pipeline moves whenever the output slot frees
    logic en, accept, skin, bad;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign skin     = accept && (s_tuser == CmdSkin);

    logic [3:0]       bad_vec;
    logic [3:0][7:0]  rd_addr;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            bad_vec[k] = {1'b0, bone_indices[8*k +: 8]} >= BoneLim;
        end
        bad = |bad_vec;
        // keep out-of-range indices inside the table; result is forced to zero
        rd_addr = bad ? '0 : bone_indices;
    end

    logic bone_wr;
    assign bone_wr = accept && (s_tuser == CmdWrite) && (matrix_slot != FinalSlot)
                   && ({2'b0, matrix_slot} < BoneLim);

    // final (model) matrix, identity after reset
    mat_t fin_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < 16; e++) begin
                fin_reg[e] <= (e % 5 == 0) ? OneQ16 : 32'h0;
            end
        end else if (accept && (s_tuser == CmdWrite) && (matrix_slot == FinalSlot)) begin
            fin_reg[element_index] <= element_value;
        end
    end

    // per-stage tags and side data
    logic [Depth-1:0] v_reg, bad_reg;
    logic [63:0]      w_reg;
    mat_t             fin_p_reg [3];
    logic [2:0][31:0] pos_p_reg [5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Depth-2:0], skin};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bad_reg      <= {bad_reg[Depth-2:0], bad};
            w_reg        <= weights;
            fin_p_reg[0] <= fin_reg;
            fin_p_reg[1] <= fin_p_reg[0];
            fin_p_reg[2] <= fin_p_reg[1];
            pos_p_reg[0] <= pos;
            for (int i = 1; i < 5; i++) begin
                pos_p_reg[i] <= pos_p_reg[i-1];
            end
        end
    end

    mat_t [3:0]       bones;
    mat_t             blend, comb;
    logic             sat_b, sat_c, sat_x;
    logic [2:0][31:0] res;

    lbvs_bone_mem #(.BONE_COUNT(BONE_COUNT)) u_mem (
        .aclk    (aclk),
        .rd_en   (en),
        .wr_en   (bone_wr),
        .wr_addr ({1'b0, matrix_slot}),
        .wr_elem (element_index),
        .wr_data (element_value),
        .rd_addr (rd_addr),
        .rd_data (bones)
    );

    lbvs_blend u_blend (
        .aclk    (aclk),
        .en      (en),
        .bones   (bones),
        .weights (w_reg),
        .blend   (blend),
        .sat     (sat_b)
    );

    lbvs_combine u_comb (
        .aclk   (aclk),
        .en     (en),
        .fin    (fin_p_reg[2]),
        .blend  (blend),
        .sat_in (sat_b),
        .comb   (comb),
        .sat    (sat_c)
    );

    lbvs_xform u_xform (
        .aclk   (aclk),
        .en     (en),
        .comb   (comb),
        .pos    (pos_p_reg[4]),
        .sat_in (sat_c),
        .res    (res),
        .sat    (sat_x)
    );

    // bad index: zero position, no saturation flag
    assign m_tvalid = v_reg[Depth-1];
    assign m_tdata  = bad_reg[Depth-1] ? '0 : res;
    assign m_tuser  = {bad_reg[Depth-1], sat_x && !bad_reg[Depth-1]};

endmodule

/* src/lbvs_checker.sv */
// ----------------------------------------------------------------------------
// lbvs_checker
// Port-level checks for the vertex skinner, bound to the top level.
// ----------------------------------------------------------------------------
module lbvs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [239:0] s_tdata,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // bad index gives a zero result without saturation
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("bad index result not zero");

    // input side is free exactly when the output slot is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not track output slot");

    // a waiting input transaction is held until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input changed while waiting");

    // pipeline empty after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind linear_blend_vertex_skinning lbvs_checker u_lbvs_checker (.*);
